// ===== rtl/occupancy_grid_rescaler_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef OCCUPANCY_GRID_RESCALER_TOP_DEFINES_SVH
`define OCCUPANCY_GRID_RESCALER_TOP_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define OGR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked at the edge after the antecedent.
`define OGR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ogr_pkg.sv =====
`default_nettype none
package ogr_pkg;

   // default sizes of the grid store and factor limit
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_FACTOR = 8;

   // fixed field widths
   localparam int CELL_W  = 11;
   localparam int OCC_W   = 8;
   localparam int SIZE_W  = 9;
   localparam int FACT_W  = 4;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam int REG_IW  = 2;

   // request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // register indexes
   localparam logic [REG_IW-1:0] REG_SOURCE_WIDTH  = 2'd0;
   localparam logic [REG_IW-1:0] REG_SOURCE_HEIGHT = 2'd1;
   localparam logic [REG_IW-1:0] REG_SCALE_FACTOR  = 2'd2;
   localparam logic [REG_IW-1:0] REG_REFINE_MODE   = 2'd3;

   // register reset values
   localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = 9'd256;
   localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = 9'd256;
   localparam logic [FACT_W-1:0] RST_SCALE_FACTOR  = 4'd1;
   localparam logic              RST_REFINE_MODE   = 1'b0;

   typedef struct packed {
      logic [SIZE_W-1:0] source_width;
      logic [SIZE_W-1:0] source_height;
      logic [FACT_W-1:0] scale_factor;
      logic              refine_mode;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/ogr_csr.sv =====
`default_nettype none
module ogr_csr (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [ogr_pkg::CSR_AW-1:0] paddr,
   input  wire logic [ogr_pkg::CSR_DW-1:0] pwdata,
   output logic      [ogr_pkg::CSR_DW-1:0] prdata,
   output logic                            pready,
   output ogr_pkg::cfg_type                cfg
);
   import ogr_pkg::*;

   cfg_type            cfg_ff;
   logic [REG_IW-1:0]  reg_idx;
   logic               wr_strobe;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_AW-1:2];
   assign wr_strobe = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= RST_SOURCE_WIDTH;
         cfg_ff.source_height <= RST_SOURCE_HEIGHT;
         cfg_ff.scale_factor  <= RST_SCALE_FACTOR;
         cfg_ff.refine_mode   <= RST_REFINE_MODE;
      end else if (wr_strobe) begin
         unique case (reg_idx)
            REG_SOURCE_WIDTH:  cfg_ff.source_width  <= pwdata[SIZE_W-1:0];
            REG_SOURCE_HEIGHT: cfg_ff.source_height <= pwdata[SIZE_W-1:0];
            REG_SCALE_FACTOR:  cfg_ff.scale_factor  <= pwdata[FACT_W-1:0];
            REG_REFINE_MODE:   cfg_ff.refine_mode   <= pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SOURCE_WIDTH:  prdata = CSR_DW'(cfg_ff.source_width);
         REG_SOURCE_HEIGHT: prdata = CSR_DW'(cfg_ff.source_height);
         REG_SCALE_FACTOR:  prdata = CSR_DW'(cfg_ff.scale_factor);
         REG_REFINE_MODE:   prdata = CSR_DW'(cfg_ff.refine_mode);
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/ogr_grid_mem.sv =====
`default_nettype none
module ogr_grid_mem #(
   parameter int DEPTH = ogr_pkg::DEF_MAX_WIDTH * ogr_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [ogr_pkg::OCC_W-1:0]  wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [ogr_pkg::OCC_W-1:0]  rd_data
);
   import ogr_pkg::*;

   logic [OCC_W-1:0] grid_mem [DEPTH];
   logic [OCC_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ogr_div.sv =====
`default_nettype none
// two-lane restoring divider, one quotient bit per cycle on both lanes
module ogr_div #(
   parameter int MAX_FACTOR = ogr_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [ogr_pkg::CELL_W-1:0]        num_x,
   input  wire logic [ogr_pkg::CELL_W-1:0]        num_y,
   input  wire logic [$clog2(MAX_FACTOR+1)-1:0]   den,
   output logic                                   done,
   output logic      [ogr_pkg::CELL_W-1:0]        quo_x,
   output logic      [ogr_pkg::CELL_W-1:0]        quo_y
);
   import ogr_pkg::*;

   localparam int F_W   = $clog2(MAX_FACTOR + 1);
   localparam int CNT_W = $clog2(CELL_W + 1);

   logic [CELL_W-1:0] quo_ff  [2];
   logic [F_W-1:0]    rem_ff  [2];
   logic [CELL_W-1:0] quo_in  [2];
   logic [F_W-1:0]    rem_in  [2];
   logic [F_W:0]      trial   [2];
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   assign done  = done_ff;
   assign quo_x = quo_ff[0];
   assign quo_y = quo_ff[1];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         trial[i] = {rem_ff[i], quo_ff[i][CELL_W-1]};
         if (trial[i] >= {1'b0, den}) begin
            rem_in[i] = F_W'(trial[i] - {1'b0, den});
            quo_in[i] = {quo_ff[i][CELL_W-2:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][F_W-1:0];
            quo_in[i] = {quo_ff[i][CELL_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= CNT_W'(CELL_W);
            quo_ff[0] <= num_x;
            quo_ff[1] <= num_y;
            rem_ff[0] <= '0;
            rem_ff[1] <= '0;
         end else if (busy_ff) begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ogr_ctrl.sv =====
`default_nettype none
module ogr_ctrl #(
   parameter int MAX_WIDTH  = ogr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ogr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = ogr_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire ogr_pkg::cfg_type                        cfg,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic                                    req_command,
   input  wire logic [ogr_pkg::CELL_W-1:0]              req_cell_x,
   input  wire logic [ogr_pkg::CELL_W-1:0]              req_cell_y,
   input  wire logic [ogr_pkg::OCC_W-1:0]               req_cell_value,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic      [ogr_pkg::OCC_W-1:0]               rsp_occupancy,
   output logic                                         rsp_out_of_range,
   output logic                                         mem_wr_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      mem_wr_addr,
   output logic      [ogr_pkg::OCC_W-1:0]               mem_wr_data,
   output logic                                         mem_rd_en,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      mem_rd_addr,
   input  wire logic [ogr_pkg::OCC_W-1:0]               mem_rd_data,
   output logic                                         div_start,
   output logic      [ogr_pkg::CELL_W-1:0]              div_num_x,
   output logic      [ogr_pkg::CELL_W-1:0]              div_num_y,
   output logic      [$clog2(MAX_FACTOR+1)-1:0]         div_den,
   input  wire logic                                    div_done,
   input  wire logic [ogr_pkg::CELL_W-1:0]              div_quo_x,
   input  wire logic [ogr_pkg::CELL_W-1:0]              div_quo_y
);
   import ogr_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int F_W    = $clog2(MAX_FACTOR + 1);
   localparam int WH_W   = (W_W > H_W) ? W_W : H_W;
   localparam int D_W    = (WH_W > CELL_W) ? WH_W : CELL_W;
   localparam int P_W    = D_W + F_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_RANGE, ST_DIV_WAIT, ST_ADDR, ST_WALK, ST_DRAIN, ST_DONE
   } state_type;

   state_type         state_ff;
   logic [CELL_W-1:0] x_ff, y_ff;
   logic [P_W-1:0]    xf_ff, yf_ff, wf_ff, hf_ff;
   logic [COL_W-1:0]  base_col_ff;
   logic [ROW_W-1:0]  base_row_ff;
   logic [F_W-1:0]    win_ff, c_ff, r_ff;
   logic [ADDR_W-1:0] row_addr_ff;
   logic              rd_pend_ff;
   logic [OCC_W-1:0]  best_ff;
   logic              res_oob_ff;
   logic              rsp_valid_ff;
   logic [OCC_W-1:0]  rsp_occ_ff;
   logic              rsp_oob_ff;

   logic [W_W-1:0]    used_w;
   logic [H_W-1:0]    used_h;
   logic [F_W-1:0]    used_f;
   logic [D_W-1:0]    wx_ext, wy_ext, qx_ext, qy_ext;
   logic              wr_ok;
   logic              in_range;
   logic              rsp_free;

   // saturate the configured sizes to the store and the factor to its limit; factor 0 counts as 1
   always_comb begin
      if (32'(cfg.source_width) > 32'(MAX_WIDTH)) used_w = W_W'(MAX_WIDTH);
      else                                         used_w = W_W'(cfg.source_width);
      if (32'(cfg.source_height) > 32'(MAX_HEIGHT)) used_h = H_W'(MAX_HEIGHT);
      else                                           used_h = H_W'(cfg.source_height);
      priority if (cfg.scale_factor == '0)                   used_f = F_W'(1);
      else if (32'(cfg.scale_factor) > 32'(MAX_FACTOR))      used_f = F_W'(MAX_FACTOR);
      else                                                   used_f = F_W'(cfg.scale_factor);
   end

   // source cell writes go straight to the store at accept; writes outside the source size are dropped
   assign wx_ext      = D_W'(req_cell_x);
   assign wy_ext      = D_W'(req_cell_y);
   assign wr_ok       = (P_W'(req_cell_x) < P_W'(used_w)) && (P_W'(req_cell_y) < P_W'(used_h));
   assign req_ready   = (state_ff == ST_IDLE);
   assign mem_wr_en   = req_ready && req_valid && (req_command == CMD_WRITE) && wr_ok;
   assign mem_wr_addr = ADDR_W'(wy_ext[ROW_W-1:0] * MAX_WIDTH) + ADDR_W'(wx_ext[COL_W-1:0]);
   assign mem_wr_data = req_cell_value;

   // coarsen: window must fit, (x+1)*f <= w; refine: x < w*f
   always_comb begin
      if (cfg.refine_mode) begin
         in_range = (P_W'(x_ff) < wf_ff) && (P_W'(y_ff) < hf_ff);
      end else begin
         in_range = (xf_ff + P_W'(used_f) <= P_W'(used_w)) &&
                    (yf_ff + P_W'(used_f) <= P_W'(used_h));
      end
   end

   assign div_start = (state_ff == ST_RANGE) && in_range && cfg.refine_mode;
   assign div_num_x = x_ff;
   assign div_num_y = y_ff;
   assign div_den   = used_f;
   assign qx_ext    = D_W'(div_quo_x);
   assign qy_ext    = D_W'(div_quo_y);

   assign mem_rd_en   = (state_ff == ST_WALK);
   assign mem_rd_addr = row_addr_ff + ADDR_W'(c_ff);

   assign rsp_free         = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_out_of_range = rsp_oob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == ST_WALK);
         if (rd_pend_ff && (mem_rd_data > best_ff)) begin
            best_ff <= mem_rd_data;
         end
         // ST_DONE reloads the response register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && (req_command == CMD_READ)) begin
                  x_ff     <= req_cell_x;
                  y_ff     <= req_cell_y;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               xf_ff    <= P_W'(x_ff) * P_W'(used_f);
               yf_ff    <= P_W'(y_ff) * P_W'(used_f);
               wf_ff    <= P_W'(used_w) * P_W'(used_f);
               hf_ff    <= P_W'(used_h) * P_W'(used_f);
               state_ff <= ST_RANGE;
            end
            ST_RANGE: begin
               res_oob_ff <= !in_range;
               priority if (!in_range) begin
                  best_ff  <= '0;
                  state_ff <= ST_DONE;
               end else if (cfg.refine_mode) begin
                  state_ff <= ST_DIV_WAIT;
               end else begin
                  base_col_ff <= xf_ff[COL_W-1:0];
                  base_row_ff <= yf_ff[ROW_W-1:0];
                  win_ff      <= used_f;
                  state_ff    <= ST_ADDR;
               end
            end
            ST_DIV_WAIT: begin
               // refine reads a one-cell window at the divided position
               if (div_done) begin
                  base_col_ff <= qx_ext[COL_W-1:0];
                  base_row_ff <= qy_ext[ROW_W-1:0];
                  win_ff      <= F_W'(1);
                  state_ff    <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               row_addr_ff <= ADDR_W'(base_row_ff * MAX_WIDTH) + ADDR_W'(base_col_ff);
               c_ff        <= '0;
               r_ff        <= '0;
               best_ff     <= '0;
               state_ff    <= ST_WALK;
            end
            ST_WALK: begin
               if (c_ff == win_ff - 1'b1) begin
                  c_ff        <= '0;
                  row_addr_ff <= row_addr_ff + ADDR_W'(MAX_WIDTH);
                  if (r_ff == win_ff - 1'b1) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     r_ff <= r_ff + 1'b1;
                  end
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               // last read data folds into best_ff at this edge
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_occ_ff   <= best_ff;
                  rsp_oob_ff   <= res_oob_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/occupancy_grid_rescaler_top.sv =====
// A write request is stored at its accept edge if in the source grid; no response.
// Coarsen read: MUL, RANGE, ADDR, walk of the f*f window (one store read per cycle),
// DRAIN, DONE. Refine read: 11-step divider after RANGE, then a one-cell walk;
// out of range: RANGE to DONE. One request in flight; the window walk sets the rate.
// Reset: synchronous, active high; clears control and registers, grid contents stay
// undefined until written.
`default_nettype none
module occupancy_grid_rescaler_top #(
   parameter int MAX_WIDTH  = ogr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = ogr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_FACTOR = ogr_pkg::DEF_MAX_FACTOR
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_command,
   input  wire logic [ogr_pkg::CELL_W-1:0] req_cell_x,
   input  wire logic [ogr_pkg::CELL_W-1:0] req_cell_y,
   input  wire logic [ogr_pkg::OCC_W-1:0]  req_cell_value,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [ogr_pkg::OCC_W-1:0]  rsp_occupancy,
   output logic                            rsp_out_of_range,
   // register port
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [ogr_pkg::CSR_AW-1:0] paddr,
   input  wire logic [ogr_pkg::CSR_DW-1:0] pwdata,
   output logic      [ogr_pkg::CSR_DW-1:0] prdata,
   output logic                            pready
);
   import ogr_pkg::*;

   // store is row-major: address = row * MAX_WIDTH + column
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int F_W    = $clog2(MAX_FACTOR + 1);

   cfg_type            cfg;
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [OCC_W-1:0]   mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [OCC_W-1:0]   mem_rd_data;
   logic               div_start;
   logic [CELL_W-1:0]  div_num_x, div_num_y;
   logic [F_W-1:0]     div_den;
   logic               div_done;
   logic [CELL_W-1:0]  div_quo_x, div_quo_y;

   // configuration registers; the user must write them only while the block is idle, the block does not enforce it
   ogr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // grid store: one write and one registered read port. Only one request is
   // in flight and a write completes at its accept edge, so a later read never
   // overlaps a write to the same cell and no forwarding is needed.
   ogr_grid_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // refine mode maps an output cell back by x / f and y / f
   ogr_div #(
      .MAX_FACTOR (MAX_FACTOR)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num_x (div_num_x),
      .num_y (div_num_y),
      .den   (div_den),
      .done  (div_done),
      .quo_x (div_quo_x),
      .quo_y (div_quo_y)
   );

   // sequencer: range check, window walk with running maximum, and the
   // response register that lets a new request in while a response waits
   ogr_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_FACTOR (MAX_FACTOR)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_out_of_range (rsp_out_of_range),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .div_start        (div_start),
      .div_num_x        (div_num_x),
      .div_num_y        (div_num_y),
      .div_den          (div_den),
      .div_done         (div_done),
      .div_quo_x        (div_quo_x),
      .div_quo_y        (div_quo_y)
   );

endmodule
`default_nettype wire

// ===== rtl/ogr_checker.sv =====
`default_nettype none
`include "occupancy_grid_rescaler_top_defines.svh"
module ogr_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_command,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [ogr_pkg::OCC_W-1:0]  rsp_occupancy,
   input wire logic                       rsp_out_of_range
);
   import ogr_pkg::*;

   // stalled response holds
   `OGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_occupancy) && $stable(rsp_out_of_range), "stalled response changed")

   // out-of-range responses carry zero occupancy
   `OGR_ASSERT_SAME(a_oob_zero, rsp_valid && rsp_out_of_range, rsp_occupancy == '0, "out of range response with nonzero occupancy")

   // a read request keeps the block busy for at least the next cycle
   `OGR_ASSERT_NEXT(a_read_busy, req_valid && req_ready && req_command == CMD_READ, !req_ready, "request taken while a read is in progress")

   // a write request taken while no response is pending does not raise one
   `OGR_ASSERT_NEXT(a_write_silent, req_valid && req_ready && req_command == CMD_WRITE && !rsp_valid, !rsp_valid, "response after a write request")

endmodule

bind occupancy_grid_rescaler_top ogr_checker u_ogr_checker (.*);
`default_nettype wire

// ===== sim/tb_occupancy_grid_rescaler_top.sv =====
`timescale 1ns / 100ps

module tb_occupancy_grid_rescaler_top;
   import ogr_pkg::*;

   // store geometry as built (DUT uses package defaults)
   localparam int GRID_W      = DEF_MAX_WIDTH;
   localparam int GRID_H      = DEF_MAX_HEIGHT;
   localparam int GRID_CELLS  = GRID_W * GRID_H;
   localparam int FACTOR_CAP  = DEF_MAX_FACTOR;

   // run shape
   localparam int PHASE_COUNT   = 13;
   localparam int PHASE_ITEMS   = 110;
   // longest response is the 8x8 window walk, pad it
   localparam int SETTLE_CYCLES = 80;
   // worst quiet stretch comes from settle + csr writes + gap
   localparam int QUIET_LIMIT   = 2000;

   // ---------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------
   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic                req_command    = CMD_WRITE;
   logic [CELL_W-1:0]   req_cell_x     = '0;
   logic [CELL_W-1:0]   req_cell_y     = '0;
   logic [OCC_W-1:0]    req_cell_value = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [OCC_W-1:0]    rsp_occupancy;
   logic                rsp_out_of_range;
   logic                psel           = 1'b0;
   logic                penable        = 1'b0;
   logic                pwrite         = 1'b0;
   logic [CSR_AW-1:0]   paddr          = '0;
   logic [CSR_DW-1:0]   pwdata         = '0;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   occupancy_grid_rescaler_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_value   (req_cell_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_out_of_range (rsp_out_of_range),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Grid shadow: register copy, store copy, and which cells hold data
   // ---------------------------------------------------------------
   typedef struct {
      logic [OCC_W-1:0] occ;
      logic             oor;
   } view_result_type;

   typedef int cell_list_type[$];

   cfg_type          grid_cfg = '{source_width:  RST_SOURCE_WIDTH,
                                   source_height: RST_SOURCE_HEIGHT,
                                   scale_factor:  RST_SCALE_FACTOR,
                                   refine_mode:   RST_REFINE_MODE};
   logic [OCC_W-1:0] grid_model   [GRID_CELLS];
   bit               grid_written [GRID_CELLS];
   view_result_type  pending_views[$];

   int  mismatch_count   = 0;
   int  requests_sent    = 0;
   int  writes_sent      = 0;
   int  reads_sent       = 0;
   int  oor_reads        = 0;
   int  reads_checked    = 0;
   int  settings_applied = 0;
   bit  sender_idles     = 1'b1;
   bit  stalls_on        = 1'b1;
   int  stall_left       = 0;
   int  quiet_cycles     = 0;

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // sizes as the block uses them: clamp sizes to the store, factor to its cap, factor 0 -> 1
   function automatic int grid_cols();
      return (grid_cfg.source_width > GRID_W) ? GRID_W : int'(grid_cfg.source_width);
   endfunction

   function automatic int grid_rows();
      return (grid_cfg.source_height > GRID_H) ? GRID_H : int'(grid_cfg.source_height);
   endfunction

   function automatic int grid_factor();
      if (grid_cfg.scale_factor == 0) return 1;
      return (grid_cfg.scale_factor > FACTOR_CAP) ? FACTOR_CAP : int'(grid_cfg.scale_factor);
   endfunction

   function automatic void view_dims(output int ow, output int oh);
      if (grid_cfg.refine_mode) begin
         ow = grid_cols() * grid_factor();
         oh = grid_rows() * grid_factor();
      end else begin
         ow = grid_cols() / grid_factor();
         oh = grid_rows() / grid_factor();
      end
   endfunction

   // store addresses a view read touches; empty when out of range
   function automatic void read_cells(input int x, input int y, output bit oor,
                                      output cell_list_type cells);
      int ow, oh, f, w, h;
      view_dims(ow, oh);
      f = grid_factor();
      w = grid_cols();
      h = grid_rows();
      cells = {};
      oor = (x >= ow) || (y >= oh);
      if (oor) return;
      if (grid_cfg.refine_mode) begin
         cells = {cells, (y / f) * GRID_W + x / f};
      end else begin
         for (int r = y * f; r < y * f + f; r++)
            for (int c = x * f; c < x * f + f; c++)
               if (r < h && c < w) cells = {cells, r * GRID_W + c};
      end
   endfunction

   // ---------------------------------------------------------------
   // Request side: drive at negedge, accept seen at posedge
   // ---------------------------------------------------------------
   task automatic send_request(input logic cmd, input int x, input int y, input int value,
                               input bit pinned = 1'b0,
                               input logic [OCC_W-1:0] pin_occ = '0,
                               input logic pin_oor = 1'b0);
      int              gap;
      bit              oor;
      cell_list_type   cells;
      logic [OCC_W-1:0] peak;
      view_result_type due;
      gap = (sender_idles && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_cell_x     <= x[CELL_W-1:0];
      req_cell_y     <= y[CELL_W-1:0];
      req_cell_value <= value[OCC_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (cmd == CMD_WRITE) begin
         writes_sent++;
         // writes outside the source grid are dropped
         if (x < grid_cols() && y < grid_rows()) begin
            grid_model[y * GRID_W + x]   = value[OCC_W-1:0];
            grid_written[y * GRID_W + x] = 1'b1;
         end
      end else begin
         reads_sent++;
         read_cells(x, y, oor, cells);
         // window maximum, floored at zero; refine has a single cell
         peak = '0;
         foreach (cells[i])
            if (grid_model[cells[i]] > peak) peak = grid_model[cells[i]];
         due.occ = pinned ? pin_occ : peak;
         due.oor = pinned ? pin_oor : oor;
         if (due.oor) oor_reads++;
         pending_views = {pending_views, due};
      end
   endtask

   // make sure every cell a read will touch holds data before the read
   task automatic fill_window(input int x, input int y);
      bit            oor;
      cell_list_type cells;
      read_cells(x, y, oor, cells);
      foreach (cells[i])
         if (!grid_written[cells[i]])
            send_request(CMD_WRITE, cells[i] % GRID_W, cells[i] / GRID_W,
                         $urandom_range(0, 255));
   endtask

   // hold the sender until all reads are answered and the block is quiet
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Register port: setup then access; junk above the field width
   // ---------------------------------------------------------------
   task automatic csr_write(input logic [REG_IW-1:0] index, input int value);
      logic [CSR_DW-1:0] keep;
      logic [CSR_DW-1:0] word;
      case (index)
         REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: keep = (1 << SIZE_W) - 1;
         REG_SCALE_FACTOR:                    keep = (1 << FACT_W) - 1;
         REG_REFINE_MODE:                     keep = 1;
         default:                             keep = '0;
      endcase
      word = ($urandom() & ~keep) | (value & keep);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_SOURCE_WIDTH:  grid_cfg.source_width  = word[SIZE_W-1:0];
         REG_SOURCE_HEIGHT: grid_cfg.source_height = word[SIZE_W-1:0];
         REG_SCALE_FACTOR:  grid_cfg.scale_factor  = word[FACT_W-1:0];
         REG_REFINE_MODE:   grid_cfg.refine_mode   = word[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic program_grid(input int w, input int h, input int f, input int m);
      csr_write(REG_SOURCE_WIDTH, w);
      csr_write(REG_SOURCE_HEIGHT, h);
      csr_write(REG_SCALE_FACTOR, f);
      csr_write(REG_REFINE_MODE, m);
      settings_applied++;
   endtask

   // ---------------------------------------------------------------
   // Response side: random stall bursts, check at posedge
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 14);   // remaining stall burst
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready  <= 1'b1;
      end
   end

   always @(posedge clock) begin : view_check
      view_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_views.size() == 0) begin
            flag_mismatch($sformatf("response with no read outstanding (occ %0d oor %0b)",
                                    rsp_occupancy, rsp_out_of_range));
         end else begin
            due = pending_views.pop_front();
            reads_checked++;
            if (rsp_occupancy !== due.occ)
               flag_mismatch($sformatf("occupancy expected %0d got %0d",
                                       due.occ, rsp_occupancy));
            if (rsp_out_of_range !== due.oor)
               flag_mismatch($sformatf("out_of_range expected %0b got %0b",
                                       due.oor, rsp_out_of_range));
         end
      end
   end

   // watchdog: too long with no request and no response moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: %0d cycles without a handshake", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Directed plan rows
   // ---------------------------------------------------------------
   typedef enum logic [1:0] {ROW_WRITE, ROW_READ, ROW_SETTING} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      int               a, b, c, d;   // x,y,value  or  width,height,factor,mode
      bit               pinned;
      logic [OCC_W-1:0] occ;
      logic             oor;
   } plan_row_type;

   function automatic plan_row_type plan_write(input int x, input int y, input int v);
      return '{kind: ROW_WRITE, a: x, b: y, c: v, d: 0, pinned: 1'b0, occ: '0, oor: 1'b0};
   endfunction

   function automatic plan_row_type plan_read(input int x, input int y, input int occ,
                                              input bit oor);
      return '{kind: ROW_READ, a: x, b: y, c: 0, d: 0, pinned: 1'b1,
               occ: occ[OCC_W-1:0], oor: oor};
   endfunction

   function automatic plan_row_type plan_setting(input int w, input int h, input int f,
                                                 input int m);
      return '{kind: ROW_SETTING, a: w, b: h, c: f, d: m, pinned: 1'b0, occ: '0, oor: 1'b0};
   endfunction

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      plan_row_type plan[$];
      int           mark, x, y, value, w, h, ow, oh, reach;
      bit           wide;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = {
         // reset setting: 256x256, factor 1, coarsen
         plan_write(0, 0, 255),
         plan_read(0, 0, 255, 0),
         plan_write(255, 255, 0),
         plan_read(255, 255, 0, 0),         // far corner
         plan_read(256, 0, 0, 1),           // just past the edge
         plan_read(0, 2047, 0, 1),
         plan_write(2047, 2047, 8'hAA),     // outside source, dropped
         plan_write(255, 0, 8'hC3),
         // sizes above the store clamp to 256
         plan_setting(511, 300, 1, 0),
         plan_read(255, 0, 8'hC3, 0),
         plan_read(0, 256, 0, 1),
         // 2x2 source, factor 2: one output cell = max of all four
         plan_setting(2, 2, 2, 0),
         plan_write(0, 0, 8'h10),
         plan_write(1, 0, 8'h7F),
         plan_write(0, 1, 8'h01),
         plan_write(1, 1, 8'h80),
         plan_write(2, 0, 8'h33),           // past width 2, dropped
         plan_read(0, 0, 8'h80, 0),
         plan_read(1, 0, 0, 1),
         // factor 15 clamps to 8: refine view is 16x16
         plan_setting(2, 2, 15, 1),
         plan_read(15, 15, 8'h80, 0),
         plan_read(16, 0, 0, 1),
         plan_read(7, 8, 8'h01, 0),
         // empty source grid: writes dropped, reads out of range
         plan_setting(0, 2, 0, 0),
         plan_write(0, 0, 8'h55),
         plan_read(0, 0, 0, 1),
         // factor 0 acts as 1; the dropped write left (0,0) alone
         plan_setting(2, 2, 0, 1),
         plan_read(1, 1, 8'h80, 0),
         plan_read(2, 0, 0, 1),
         plan_read(0, 0, 8'h10, 0)
      };

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_WRITE: send_request(CMD_WRITE, plan[i].a, plan[i].b, plan[i].c);
            ROW_READ: begin
               fill_window(plan[i].a, plan[i].b);
               send_request(CMD_READ, plan[i].a, plan[i].b, 0,
                            plan[i].pinned, plan[i].occ, plan[i].oor);
            end
            default: begin
               settle_idle();
               program_grid(plan[i].a, plan[i].b, plan[i].c, plan[i].d);
            end
         endcase
      end

      // random phases, each under its own register setting; the store
      // carries over, so later phases read cells written earlier
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle_idle();
         case (p)
            0: program_grid(256, 256, 8, 0);   // biggest window walk
            1: program_grid(1, 1, 1, 1);       // single cell
            2: program_grid(256, 256, 8, 1);   // 2048-wide refined view
            3: program_grid(1, 256, 1, 0);
            default: begin
               w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24);
               h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 24);
               program_grid(w, h,
                            ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(1, 8),
                            $urandom_range(0, 1));
            end
         endcase
         // some phases run without gaps or stalls; the last one has neither
         sender_idles = (p % 4 != 2) && (p != PHASE_COUNT - 1);
         stalls_on    = (p % 5 != 3) && (p != PHASE_COUNT - 1);

         mark = requests_sent;
         while (requests_sent - mark < PHASE_ITEMS) begin
            // now and then let everything drain mid-phase
            if (sender_idles && $urandom_range(0, 99) == 0) settle_idle();
            w = grid_cols();
            h = grid_rows();
            if ($urandom_range(0, 1) == 0) begin
               if (w > 0 && h > 0 && $urandom_range(0, 6) != 0) begin
                  x = $urandom_range(0, w - 1);
                  y = $urandom_range(0, h - 1);
               end else begin
                  x = $urandom_range(0, 2047);
                  y = $urandom_range(0, 2047);
               end
               value = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 255 : 0)
                                                   : $urandom_range(0, 255);
               send_request(CMD_WRITE, x, y, value);
            end else begin
               view_dims(ow, oh);
               if (ow > 0 && oh > 0 && $urandom_range(0, 4) != 0) begin
                  // mostly near the origin so coarse windows get reused
                  wide  = ($urandom_range(0, 4) == 0);
                  reach = grid_cfg.refine_mode ? 7 : 1;
                  x = $urandom_range(0, (wide || ow - 1 < reach) ? ow - 1 : reach);
                  y = $urandom_range(0, (wide || oh - 1 < reach) ? oh - 1 : reach);
               end else begin
                  x = $urandom_range(0, 2047);
                  y = $urandom_range(0, 2047);
               end
               fill_window(x, y);
               send_request(CMD_READ, x, y, $urandom_range(0, 255));
            end
         end
      end

      // drain and give the block its tail cycles
      settle_idle();
      if (pending_views.size() != 0)
         flag_mismatch($sformatf("%0d reads never answered", pending_views.size()));

      $display("covered %0d requests: %0d writes, %0d reads (%0d out of range)",
               requests_sent, writes_sent, reads_sent, oor_reads);
      $display("checked %0d responses across %0d register settings, %0d mismatches",
               reads_checked, settings_applied, mismatch_count);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
